// ----- src/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, codes and widths of the multi-LED blink controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbc_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_NUM_LEDS  = 3;
  localparam int DEF_TICK_BITS = 16;

  // Field widths
  localparam int LED_IDX_W = 3;
  localparam int MODE_W    = 3;
  localparam int TICKS_W   = 16;
  localparam int DUR_W     = 17;
  localparam int STATUS_W  = 2;
  localparam int PIN_W     = 3;
  localparam int LEDS_W    = 2;
  localparam int POL_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 3;
  // Wide enough for any LED count and any LED index
  localparam int CMP_W     = LED_IDX_W + 1;

  localparam logic [LEDS_W-1:0] DEFAULT_LEDS = LEDS_W'(2);
  localparam logic [MODE_W-1:0] MODE_MAX     = MODE_W'(3);

  localparam logic ACT_TICK     = 1'b0;
  localparam logic ACT_SET_MODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LEDS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_ON        = 2'd1,
    MODE_BLINK     = 2'd2,
    MODE_SELECTIVE = 2'd3
  } led_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LED  = 2'd1,
    STATUS_BAD_MODE = 2'd2
  } status_t;

  // Operation broadcast to every LED lane
  typedef struct packed {
    logic                      tick;
    led_mode_t                 mode;
    logic [TICKS_W-1:0]        on_ticks;
    logic [TICKS_W-1:0]        off_ticks;
    logic signed [DUR_W-1:0]   blink_duration;
    logic                      end_lit;
  } lbc_op_t;

endpackage

// ----- src/lbc_in_if.sv -----
// ----------------------------------------------------------------------------
// lbc_in_if
// Command channel: tick or set-mode item with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_in_if;
  import lbc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [LED_IDX_W-1:0]     led_index;
  logic [MODE_W-1:0]        mode;
  logic [TICKS_W-1:0]       on_ticks;
  logic [TICKS_W-1:0]       off_ticks;
  logic signed [DUR_W-1:0]  blink_duration;
  logic                     end_lit;

  modport source (
    output valid, action, led_index, mode, on_ticks, off_ticks, blink_duration, end_lit,
    input  ready
  );

  modport sink (
    input  valid, action, led_index, mode, on_ticks, off_ticks, blink_duration, end_lit,
    output ready
  );
endinterface

// ----- src/lbc_out_if.sv -----
// ----------------------------------------------------------------------------
// lbc_out_if
// Result channel: status and pin levels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_out_if;
  import lbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PIN_W-1:0]     pin_levels;

  modport source (
    output valid, status, pin_levels,
    input  ready
  );

  modport sink (
    input  valid, status, pin_levels,
    output ready
  );
endinterface

// ----- src/lbc_led_lane.sv -----
// ----------------------------------------------------------------------------
// lbc_led_lane
// State of one LED: mode, blink countdown, phase, lit/dark times and pin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_led_lane #(
  parameter int TICK_BITS = lbc_pkg::DEF_TICK_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             sel,
  input  logic             in_use,
  input  logic             pol,
  input  lbc_pkg::lbc_op_t op,
  output logic             pin_next
);
  import lbc_pkg::*;

  localparam int PH_W = TICK_BITS + 1;

  led_mode_t               led_mode, led_mode_next;
  logic signed [DUR_W-1:0] blink_remaining, blink_remaining_next;
  logic [PH_W-1:0]         phase_count, phase_count_next;
  logic [TICK_BITS-1:0]    lit_ticks, lit_ticks_next;
  logic [TICK_BITS-1:0]    dark_ticks, dark_ticks_next;
  logic                    ends_lit, ends_lit_next;
  logic                    pin;

  logic                    expired;
  logic                    counting;
  logic [TICK_BITS-1:0]    lit_t, dark_t;
  logic [PH_W-1:0]         phase_t, phase_inc, period, phase_adv;
  logic                    lit_bit;

  // Tick path
  always_comb begin
    expired   = (blink_remaining == '0);
    counting  = !blink_remaining[DUR_W-1] && !expired;
    lit_t     = expired ? TICK_BITS'(ends_lit) : lit_ticks;
    dark_t    = expired ? TICK_BITS'(!ends_lit) : dark_ticks;
    phase_t   = expired ? '0 : phase_count;
    period    = PH_W'(lit_t) + PH_W'(dark_t);
    phase_inc = phase_t + PH_W'(1);
    phase_adv = (phase_inc < period) ? phase_inc : '0;
    lit_bit   = (phase_adv < PH_W'(lit_t));
  end

  always_comb begin
    led_mode_next        = led_mode;
    blink_remaining_next = blink_remaining;
    phase_count_next     = phase_count;
    lit_ticks_next       = lit_ticks;
    dark_ticks_next      = dark_ticks;
    ends_lit_next        = ends_lit;
    pin_next             = pin;
    if (step && op.tick && in_use) begin
      blink_remaining_next = counting ? blink_remaining - $signed(DUR_W'(1))
                                      : blink_remaining;
      lit_ticks_next       = lit_t;
      dark_ticks_next      = dark_t;
      phase_count_next     = phase_adv;
      pin_next             = lit_bit ^ pol;
    end else if (step && !op.tick && sel) begin
      // Blink forever unless blink mode sets a duration
      blink_remaining_next = '1;
      led_mode_next        = op.mode;
      case (op.mode)
        MODE_ON: begin
          lit_ticks_next   = TICK_BITS'(1);
          dark_ticks_next  = '0;
          phase_count_next = '0;
        end
        MODE_OFF: begin
          lit_ticks_next   = '0;
          dark_ticks_next  = TICK_BITS'(1);
          phase_count_next = '0;
        end
        MODE_BLINK: begin
          // Keep the phase when already blinking
          if (led_mode != MODE_BLINK) begin
            phase_count_next = '0;
          end
          lit_ticks_next       = TICK_BITS'(op.on_ticks);
          dark_ticks_next      = TICK_BITS'(op.off_ticks);
          blink_remaining_next = op.blink_duration;
          ends_lit_next        = op.end_lit;
        end
        default: begin
          phase_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_mode        <= MODE_OFF;
      blink_remaining <= '0;
      phase_count     <= '0;
      lit_ticks       <= '0;
      dark_ticks      <= '0;
      ends_lit        <= 1'b0;
      pin             <= 1'b0;
    end else begin
      led_mode        <= led_mode_next;
      blink_remaining <= blink_remaining_next;
      phase_count     <= phase_count_next;
      lit_ticks       <= lit_ticks_next;
      dark_ticks      <= dark_ticks_next;
      ends_lit        <= ends_lit_next;
      pin             <= pin_next;
    end
  end

endmodule

// ----- src/led_blink_controller.sv -----
// ----------------------------------------------------------------------------
// led_blink_controller
// Multi-LED blink controller driven by tick and set-mode items.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries items: a tick of the frame clock, or a set-mode command that
//   reprograms one LED (off, on, blink, selective). rsp returns one item per
//   command: a status (zero on a tick) and the pin level of each LED after the
//   command has been applied.
//   cfg_we/cfg_index/cfg_data write the LED count and the polarity mask; write
//   them only while no command is in flight.
//   An item is held in the input register, then all LED lanes update in
//   parallel and the result register loads.
//   Throughput is one item per cycle while rsp does not stall; every lane
//   updates on the same advance.
//   Reset clears every LED to off with an expired blink countdown and all pins
//   low, two LEDs in use and no inverted polarity. No clearing pass is needed.
//   When rsp stalls, the result register holds and the input register takes
//   one more item; after that cmd.ready drops until rsp drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_controller #(
  parameter int NUM_LEDS  = lbc_pkg::DEF_NUM_LEDS,
  parameter int TICK_BITS = lbc_pkg::DEF_TICK_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbc_pkg::CFG_W-1:0]     cfg_data,
  lbc_in_if.sink                        cmd,
  lbc_out_if.source                     rsp
);
  import lbc_pkg::*;

  logic [LEDS_W-1:0]       leds_in_use;
  logic [POL_W-1:0]        polarity_mask;

  logic                    s1_valid;
  logic                    s1_action;
  logic [LED_IDX_W-1:0]    s1_led_index;
  logic [MODE_W-1:0]       s1_mode;
  logic [TICKS_W-1:0]      s1_on_ticks;
  logic [TICKS_W-1:0]      s1_off_ticks;
  logic signed [DUR_W-1:0] s1_blink_duration;
  logic                    s1_end_lit;

  logic                    cmd_acc;
  logic                    adv;
  logic [CMP_W-1:0]        active_cnt;
  status_t                 status_now;
  lbc_op_t                 op;
  logic [NUM_LEDS-1:0]     pin_vec;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      leds_in_use   <= DEFAULT_LEDS;
      polarity_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEDS_IN_USE: leds_in_use   <= LEDS_W'(cfg_data);
        REG_POLARITY:    polarity_mask <= POL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Handshake: advance when the result register is free or being drained
  assign adv       = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || adv;
  assign cmd_acc   = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      s1_action         <= cmd.action;
      s1_led_index      <= cmd.led_index;
      s1_mode           <= cmd.mode;
      s1_on_ticks       <= cmd.on_ticks;
      s1_off_ticks      <= cmd.off_ticks;
      s1_blink_duration <= cmd.blink_duration;
      s1_end_lit        <= cmd.end_lit;
    end
  end

  // Clamp the LED count to the LEDs built
  assign active_cnt = (CMP_W'(leds_in_use) > CMP_W'(NUM_LEDS)) ? CMP_W'(NUM_LEDS)
                                                              : CMP_W'(leds_in_use);

  // Index check comes before the mode check
  always_comb begin
    if (s1_action == ACT_TICK) begin
      status_now = STATUS_OK;
    end else if (CMP_W'(s1_led_index) >= active_cnt) begin
      status_now = STATUS_BAD_LED;
    end else if (s1_mode > MODE_MAX) begin
      status_now = STATUS_BAD_MODE;
    end else begin
      status_now = STATUS_OK;
    end
  end

  always_comb begin
    op.tick           = (s1_action == ACT_TICK);
    op.mode           = led_mode_t'(s1_mode[1:0]);
    op.on_ticks       = s1_on_ticks;
    op.off_ticks      = s1_off_ticks;
    op.blink_duration = s1_blink_duration;
    op.end_lit        = s1_end_lit;
  end

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
    logic lane_pol;
    logic lane_sel;
    logic lane_in_use;

    if (i < POL_W) begin : g_pol
      assign lane_pol = polarity_mask[i];
    end else begin : g_nopol
      assign lane_pol = 1'b0;
    end

    assign lane_in_use = (CMP_W'(i) < active_cnt);
    assign lane_sel    = (status_now == STATUS_OK) && (CMP_W'(s1_led_index) == CMP_W'(i));

    lbc_led_lane #(
      .TICK_BITS (TICK_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (adv),
      .sel      (lane_sel),
      .in_use   (lane_in_use),
      .pol      (lane_pol),
      .op       (op),
      .pin_next (pin_vec[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.status     <= STATUS_W'(status_now);
      rsp.pin_levels <= PIN_W'(pin_vec);
    end
  end

  a_tick_status_ok : assert property (@(posedge clk) disable iff (rst)
    adv && (s1_action == ACT_TICK) |=> rsp.status == STATUS_W'(STATUS_OK))
    else $error("tick item returned a non-zero status");

  a_adv_loads_result : assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp.valid)
    else $error("result register did not load after an advance");

  a_ready_only_on_stall : assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> s1_valid && rsp.valid && !rsp.ready)
    else $error("command channel stalled without a downstream stall");

endmodule

// ----- sim/led_blink_controller_test.sv -----
// ----------------------------------------------------------------------------
// led_blink_controller_test
// Self-checking bench for the multi-LED blink controller. Ticks and set-mode
// commands go in on the command channel, and a lane-by-lane predictor works
// out the status and pin levels of each one. The result channel is checked
// in order against those predictions. The run starts with directed cases,
// then holds the result side off for a long stretch, and ends with random
// traffic under several LED counts and polarity masks. Both channels idle at
// random, except in the final phase and, for the command channel, the hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_controller_test;
  import lbc_pkg::*;

  localparam int NUM         = DEF_NUM_LEDS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 215;

  typedef struct packed {
    logic                    action;
    logic [LED_IDX_W-1:0]    led_index;
    logic [MODE_W-1:0]       mode;
    logic [TICKS_W-1:0]      on_ticks;
    logic [TICKS_W-1:0]      off_ticks;
    logic signed [DUR_W-1:0] blink_duration;
    logic                    end_lit;
  } cmd_item_t;

  typedef struct packed {
    status_t          status;
    logic [PIN_W-1:0] pins;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lbc_in_if  cmd_ch ();
  lbc_out_if rsp_ch ();

  led_blink_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch.sink),
    .rsp       (rsp_ch.source)
  );

  always #5 clk = ~clk;

  // Predicted controller state
  logic [LEDS_W-1:0]       led_count;
  logic [POL_W-1:0]        pol_mask;
  led_mode_t               lane_mode    [NUM];
  logic signed [DUR_W-1:0] lane_left    [NUM];
  logic [DUR_W-1:0]        lane_phase   [NUM];
  logic [TICKS_W-1:0]      lane_lit     [NUM];
  logic [TICKS_W-1:0]      lane_dark    [NUM];
  logic                    lane_end_lit [NUM];
  logic [PIN_W-1:0]        pin_state;

  led_result_t pending_results[$];

  int  fail_count      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  settings_used   = 0;
  int  cycle_count     = 0;
  int  hold_len        = 0;
  bit  sender_gaps     = 1'b1;
  bit  quiet           = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_led_state();
    led_count = DEFAULT_LEDS;
    pol_mask  = '0;
    pin_state = '0;
    for (int i = 0; i < NUM; i++) begin
      lane_mode[i]    = MODE_OFF;
      lane_left[i]    = '0;
      lane_phase[i]   = '0;
      lane_lit[i]     = '0;
      lane_dark[i]    = '0;
      lane_end_lit[i] = 1'b0;
    end
  endfunction

  function automatic int lanes_active();
    return (int'(led_count) > NUM) ? NUM : int'(led_count);
  endfunction

  function automatic void advance_lane(int i);
    int period;
    if (lane_left[i] <= 0) begin
      // Expired countdown: reapply the end state every tick
      if (lane_left[i] == 0) begin
        lane_phase[i] = '0;
        lane_lit[i]   = lane_end_lit[i] ? TICKS_W'(1) : TICKS_W'(0);
        lane_dark[i]  = lane_end_lit[i] ? TICKS_W'(0) : TICKS_W'(1);
      end
    end else begin
      lane_left[i] = DUR_W'(lane_left[i] - 1);
    end
    period = int'(lane_lit[i]) + int'(lane_dark[i]);
    if (int'(lane_phase[i]) + 1 < period)
      lane_phase[i] = DUR_W'(lane_phase[i] + 1);
    else
      lane_phase[i] = '0;
    pin_state[i] = (int'(lane_phase[i]) < int'(lane_lit[i])) ^ pol_mask[i];
  endfunction

  function automatic status_t program_lane(cmd_item_t c);
    led_mode_t prev;
    int        i;
    i = int'(c.led_index);
    if (i >= lanes_active())
      return STATUS_BAD_LED;
    if (c.mode > MODE_MAX)
      return STATUS_BAD_MODE;
    prev         = lane_mode[i];
    lane_mode[i] = led_mode_t'(c.mode[1:0]);
    lane_left[i] = DUR_W'(-1);
    case (lane_mode[i])
      MODE_ON: begin
        lane_lit[i]   = TICKS_W'(1);
        lane_dark[i]  = '0;
        lane_phase[i] = '0;
      end
      MODE_OFF: begin
        lane_lit[i]   = '0;
        lane_dark[i]  = TICKS_W'(1);
        lane_phase[i] = '0;
      end
      MODE_BLINK: begin
        // Blink into blink keeps the running phase
        if (prev != MODE_BLINK)
          lane_phase[i] = '0;
        lane_lit[i]     = c.on_ticks;
        lane_dark[i]    = c.off_ticks;
        lane_left[i]    = c.blink_duration;
        lane_end_lit[i] = c.end_lit;
      end
      default: lane_phase[i] = '0;
    endcase
    return STATUS_OK;
  endfunction

  function automatic led_result_t apply_command(cmd_item_t c);
    led_result_t r;
    r.status = STATUS_OK;
    if (c.action == ACT_SET_MODE) begin
      r.status = program_lane(c);
    end else begin
      for (int i = 0; i < lanes_active(); i++)
        advance_lane(i);
    end
    r.pins = pin_state;
    return r;
  endfunction

  // ---------------------------------------------------- monitors and checker

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    cmd_item_t c;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.action         = cmd_ch.action;
      c.led_index      = cmd_ch.led_index;
      c.mode           = cmd_ch.mode;
      c.on_ticks       = cmd_ch.on_ticks;
      c.off_ticks      = cmd_ch.off_ticks;
      c.blink_duration = cmd_ch.blink_duration;
      c.end_lit        = cmd_ch.end_lit;
      pending_results.push_back(apply_command(c));
    end
  end

  always @(posedge clk) begin
    led_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: status %0d, pin_levels %b", rsp_ch.status, rsp_ch.pin_levels);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.pin_levels !== want.pins) begin
          $error("pin_levels: expected %b, actual %b", want.pins, rsp_ch.pin_levels);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------ drive tasks

  task automatic send_command(input cmd_item_t c);
    cmd_ch.valid          <= 1'b1;
    cmd_ch.action         <= c.action;
    cmd_ch.led_index      <= c.led_index;
    cmd_ch.mode           <= c.mode;
    cmd_ch.on_ticks       <= c.on_ticks;
    cmd_ch.off_ticks      <= c.off_ticks;
    cmd_ch.blink_duration <= c.blink_duration;
    cmd_ch.end_lit        <= c.end_lit;
    items_sent++;
    do @(posedge clk); while (!cmd_ch.ready);
    if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_results_settled();
    cmd_ch.valid <= 1'b0;
    // Let the monitor record the last accepted item first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_LEDS_IN_USE)
      led_count = data[LEDS_W-1:0];
    else
      pol_mask = data[POL_W-1:0];
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick_times(input int n);
    cmd_item_t c;
    repeat (n) begin
      c        = cmd_item_t'({$urandom, $urandom});
      c.action = ACT_TICK;
      send_command(c);
    end
  endtask

  task automatic set_led(input int idx, input int mode, input int on, input int off,
                         input int dur, input bit lit_at_end);
    cmd_item_t c;
    c.action         = ACT_SET_MODE;
    c.led_index      = LED_IDX_W'(idx);
    c.mode           = MODE_W'(mode);
    c.on_ticks       = TICKS_W'(on);
    c.off_ticks      = TICKS_W'(off);
    c.blink_duration = DUR_W'(dur);
    c.end_lit        = lit_at_end;
    send_command(c);
  endtask

  function automatic logic [TICKS_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return TICKS_W'($urandom);
      default: return TICKS_W'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic cmd_item_t random_command(input bit well_formed);
    cmd_item_t c;
    c = cmd_item_t'({$urandom, $urandom});
    if (!well_formed)
      return c;
    c.action = ($urandom_range(0, 9) < 6) ? ACT_TICK : ACT_SET_MODE;
    if (c.action == ACT_SET_MODE) begin
      if (lanes_active() > 0)
        c.led_index = LED_IDX_W'($urandom_range(0, lanes_active() - 1));
      // Weight towards blink, which holds most of the behaviour
      c.mode      = ($urandom_range(0, 1) == 1) ? MODE_W'(MODE_BLINK)
                                                : MODE_W'($urandom_range(0, 3));
      c.on_ticks  = pick_ticks();
      c.off_ticks = pick_ticks();
      case ($urandom_range(0, 9))
        0:       c.blink_duration = DUR_W'(-1);
        1:       c.blink_duration = DUR_W'($urandom);
        2:       c.blink_duration = DUR_W'(32'h10000 | $urandom_range(0, 65535));
        3:       c.blink_duration = '0;
        default: c.blink_duration = DUR_W'($urandom_range(1, 24));
      endcase
    end
    return c;
  endfunction

  // ------------------------------------------------------------- test tasks

  task automatic test_idle_after_reset();
    // Expired countdown after reset: every tick applies the dark end state
    tick_times(2);
  endtask

  task automatic test_mode_programming();
    set_led(0, MODE_ON, 0, 0, 0, 0);
    tick_times(1);
    set_led(1, MODE_BLINK, 2, 1, -1, 0);
    tick_times(3);
    // Blink into blink: phase carries over, then the countdown runs out lit
    set_led(1, MODE_BLINK, 1, 3, 3, 1);
    tick_times(5);
    set_led(0, MODE_BLINK, 0, 0, -1, 0);
    tick_times(1);
    set_led(0, MODE_BLINK, 65535, 65535, 65535, 1);
    set_led(0, MODE_BLINK, 1, 0, -65536, 0);
    tick_times(1);
    set_led(1, MODE_SELECTIVE, 0, 0, 0, 0);
    set_led(0, MODE_BLINK, 2, 2, 0, 1);
    tick_times(1);
    wait_results_settled();
  endtask

  task automatic test_rejected_commands();
    set_led(2, MODE_ON, 0, 0, 0, 0);
    set_led(7, 7, 0, 0, 0, 0);
    set_led(0, 4, 3, 3, 5, 1);
    set_led(1, 7, 3, 3, 5, 1);
    wait_results_settled();
  endtask

  task automatic test_register_extremes();
    write_register(REG_LEDS_IN_USE, CFG_W'(3));
    write_register(REG_POLARITY, CFG_W'(7));
    set_led(2, MODE_BLINK, 1, 1, -1, 0);
    tick_times(2);
    wait_results_settled();
    // No LEDs handled: everything is rejected and pins hold
    write_register(REG_LEDS_IN_USE, CFG_W'(4));
    set_led(0, MODE_ON, 0, 0, 0, 0);
    tick_times(1);
    wait_results_settled();
    write_register(REG_LEDS_IN_USE, CFG_W'(1));
    write_register(REG_POLARITY, CFG_W'(0));
    tick_times(1);
    wait_results_settled();
  endtask

  task automatic test_backpressure();
    write_register(REG_LEDS_IN_USE, CFG_W'(3));
    sender_gaps = 1'b0;
    hold_len    = 80;
    repeat (60) send_command(random_command(1'b1));
    sender_gaps = 1'b1;
    // Hold the sender until every result is back
    wait_results_settled();
  endtask

  task automatic test_random_traffic();
    int counts [8] = '{3, 1, 2, 0, 3, 2, 1, 3};
    int n;
    for (int p = 0; p < 8; p++) begin
      wait_results_settled();
      write_register(REG_LEDS_IN_USE, {1'($urandom), LEDS_W'(counts[p])});
      case (p)
        0:       write_register(REG_POLARITY, CFG_W'(7));
        1:       write_register(REG_POLARITY, CFG_W'(0));
        default: write_register(REG_POLARITY, CFG_W'($urandom_range(0, 7)));
      endcase
      quiet = (p == 7);
      n     = (counts[p] == 0) ? 60 : PHASE_ITEMS;
      repeat (n) send_command(random_command($urandom_range(0, 9) < 8));
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_LEDS_IN_USE;
    cfg_data              <= '0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.action         <= ACT_TICK;
    cmd_ch.led_index      <= '0;
    cmd_ch.mode           <= '0;
    cmd_ch.on_ticks       <= '0;
    cmd_ch.off_ticks      <= '0;
    cmd_ch.blink_duration <= '0;
    cmd_ch.end_lit        <= 1'b0;
    clear_led_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_mode_programming();
    test_rejected_commands();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_results_settled();

    $display("Summary: %0d items sent, %0d results checked, %0d register writes",
             items_sent, results_checked, settings_used);
    $display("Summary: LED counts 0 to 3, mixed polarity, long result hold-off included");
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lbc_pkg.sv
src/lbc_in_if.sv
src/lbc_out_if.sv
src/lbc_led_lane.sv
src/led_blink_controller.sv
sim/led_blink_controller_test.sv
